### sv/quadrotor_rate_and_motor_mixer_defines.svh
// Assertion macros for the checker file of the rate controller and motor mixer.
`ifndef QUADROTOR_RATE_AND_MOTOR_MIXER_DEFINES_SVH
`define QUADROTOR_RATE_AND_MOTOR_MIXER_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define QRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Delayed form of the check: consequent must hold after the antecedent.
`define QRM_ASSERT_TWO(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) else $error(msg);

`endif

### sv/qrm_pkg.sv
// Types, constants and the micro-op table of the rate controller and motor mixer.
`default_nettype none

package qrm_pkg;

  localparam int ROTOR_COUNT = 4;
  localparam int WORD_W      = 32;
  localparam int COEF_W      = 63;
  localparam int MUL_B_W     = 33;
  localparam int MUL_P_W     = 64 + MUL_B_W;
  localparam int DIV_N_W     = 96;
  localparam int CNT_W       = 7;
  localparam int STEP_W      = 5;

  localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(MUL_B_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_N_W - 1);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(31);

  localparam logic [63:0] SAT_MAX  = {1'b0, {63{1'b1}}};
  localparam logic [63:0] TERM_MAX = {3'b000, {61{1'b1}}};
  localparam logic [63:0] GAIN_XY  = 64'd1087898;
  localparam logic [63:0] GAIN_Z   = 64'd327680;

  localparam logic [WORD_W-1:0] MASS_RST = 32'd65536;
  localparam logic [COEF_W-1:0] KF_RST   = 63'd2527638;
  localparam logic [COEF_W-1:0] KM_RST   = 63'd253000;
  localparam logic [WORD_W-1:0] ARM_RST  = 32'd17039;
  localparam logic [WORD_W-1:0] JXX_RST  = 32'd164;
  localparam logic [WORD_W-1:0] JYY_RST  = 32'd164;
  localparam logic [WORD_W-1:0] JZZ_RST  = 32'd295;

  localparam logic [STEP_W-1:0] STEP_DIV0 = 5'd22;
  localparam logic [STEP_W-1:0] STEP_LAST = 5'd31;

  typedef enum logic [2:0] {
    CFG_MASS, CFG_KF, CFG_KM, CFG_ARM, CFG_JXX, CFG_JYY, CFG_JZZ
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_RATE, MODE_TORQUE, MODE_SPEED, MODE_UNKNOWN
  } mode_t;

  typedef enum logic [2:0] {OP_MUL, OP_DIV, OP_ADD, OP_SUB, OP_SQRT} op_t;

  // Operand sources: the first sixteen are datapath registers
  typedef enum logic [4:0] {
    SRC_F, SRC_T0, SRC_T1, SRC_T2, SRC_JW0, SRC_JW1, SRC_JW2, SRC_P,
    SRC_Q, SRC_G, SRC_AX, SRC_AY, SRC_TA, SRC_TX, SRC_TY, SRC_TZ,
    SRC_U0, SRC_W0, SRC_W1, SRC_W2, SRC_E0, SRC_E1, SRC_E2,
    SRC_JD0, SRC_JD1, SRC_JD2, SRC_GXY, SRC_GZ, SRC_MASS
  } src_t;

  typedef enum logic [1:0] {DSH_15, DSH_30, DSH_32} dsh_t;
  typedef enum logic [1:0] {DEN_KF, DEN_KM, DEN_ARM} den_t;

  typedef struct packed {
    op_t        op;
    src_t       a;
    src_t       b;
    src_t       dst;
    logic       sh16;
    dsh_t       dsh;
    den_t       den;
    logic       term;
    logic [1:0] rotor;
  } uop_t;

  typedef struct packed {
    logic load;
    logic start;
    logic commit;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic done;
  } status_t;

  function automatic uop_t mk(op_t op, src_t a, src_t b, src_t dst, logic sh16,
                              dsh_t dsh, den_t den, logic term, logic [1:0] rotor);
    uop_t u;
    u.op    = op;
    u.a     = a;
    u.b     = b;
    u.dst   = dst;
    u.sh16  = sh16;
    u.dsh   = dsh;
    u.den   = den;
    u.term  = term;
    u.rotor = rotor;
    return u;
  endfunction

  // Micro-program: body-rate torque, then mixer divides, then four square roots
  function automatic uop_t uop_at(logic [STEP_W-1:0] step);
    uop_t u;
    case (step)
      5'd0:  u = mk(OP_MUL, SRC_U0, SRC_MASS, SRC_F, 1'b0, DSH_15, DEN_KF, 1'b0, 2'd0);
      5'd1:  u = mk(OP_MUL, SRC_JD0, SRC_GXY, SRC_T0, 1'b0, DSH_15, DEN_KF, 1'b0, 2'd0);
      5'd2:  u = mk(OP_MUL, SRC_T0, SRC_E0, SRC_T0, 1'b1, DSH_15, DEN_KF, 1'b0, 2'd0);
      5'd3:  u = mk(OP_MUL, SRC_JD1, SRC_GXY, SRC_T1, 1'b0, DSH_15, DEN_KF, 1'b0, 2'd0);
      5'd4:  u = mk(OP_MUL, SRC_T1, SRC_E1, SRC_T1, 1'b1, DSH_15, DEN_KF, 1'b0, 2'd0);
      5'd5:  u = mk(OP_MUL, SRC_JD2, SRC_GZ, SRC_T2, 1'b0, DSH_15, DEN_KF, 1'b0, 2'd0);
      5'd6:  u = mk(OP_MUL, SRC_T2, SRC_E2, SRC_T2, 1'b1, DSH_15, DEN_KF, 1'b0, 2'd0);
      5'd7:  u = mk(OP_MUL, SRC_JD0, SRC_W0, SRC_JW0, 1'b0, DSH_15, DEN_KF, 1'b0, 2'd0);
      5'd8:  u = mk(OP_MUL, SRC_JD1, SRC_W1, SRC_JW1, 1'b0, DSH_15, DEN_KF, 1'b0, 2'd0);
      5'd9:  u = mk(OP_MUL, SRC_JD2, SRC_W2, SRC_JW2, 1'b0, DSH_15, DEN_KF, 1'b0, 2'd0);
      5'd10: u = mk(OP_MUL, SRC_JW2, SRC_W1, SRC_P, 1'b1, DSH_15, DEN_KF, 1'b0, 2'd0);
      5'd11: u = mk(OP_MUL, SRC_JW1, SRC_W2, SRC_Q, 1'b1, DSH_15, DEN_KF, 1'b0, 2'd0);
      5'd12: u = mk(OP_SUB, SRC_P, SRC_Q, SRC_G, 1'b0, DSH_15, DEN_KF, 1'b0, 2'd0);
      5'd13: u = mk(OP_ADD, SRC_T0, SRC_G, SRC_T0, 1'b0, DSH_15, DEN_KF, 1'b0, 2'd0);
      5'd14: u = mk(OP_MUL, SRC_JW0, SRC_W2, SRC_P, 1'b1, DSH_15, DEN_KF, 1'b0, 2'd0);
      5'd15: u = mk(OP_MUL, SRC_JW2, SRC_W0, SRC_Q, 1'b1, DSH_15, DEN_KF, 1'b0, 2'd0);
      5'd16: u = mk(OP_SUB, SRC_P, SRC_Q, SRC_G, 1'b0, DSH_15, DEN_KF, 1'b0, 2'd0);
      5'd17: u = mk(OP_ADD, SRC_T1, SRC_G, SRC_T1, 1'b0, DSH_15, DEN_KF, 1'b0, 2'd0);
      5'd18: u = mk(OP_MUL, SRC_JW1, SRC_W0, SRC_P, 1'b1, DSH_15, DEN_KF, 1'b0, 2'd0);
      5'd19: u = mk(OP_MUL, SRC_JW0, SRC_W1, SRC_Q, 1'b1, DSH_15, DEN_KF, 1'b0, 2'd0);
      5'd20: u = mk(OP_SUB, SRC_P, SRC_Q, SRC_G, 1'b0, DSH_15, DEN_KF, 1'b0, 2'd0);
      5'd21: u = mk(OP_ADD, SRC_T2, SRC_G, SRC_T2, 1'b0, DSH_15, DEN_KF, 1'b0, 2'd0);
      5'd22: u = mk(OP_DIV, SRC_F, SRC_F, SRC_TA, 1'b0, DSH_30, DEN_KF, 1'b1, 2'd0);
      5'd23: u = mk(OP_DIV, SRC_T0, SRC_T0, SRC_AX, 1'b0, DSH_15, DEN_ARM, 1'b0, 2'd0);
      5'd24: u = mk(OP_DIV, SRC_T1, SRC_T1, SRC_AY, 1'b0, DSH_15, DEN_ARM, 1'b0, 2'd0);
      5'd25: u = mk(OP_DIV, SRC_AX, SRC_AX, SRC_TX, 1'b0, DSH_32, DEN_KF, 1'b1, 2'd0);
      5'd26: u = mk(OP_DIV, SRC_AY, SRC_AY, SRC_TY, 1'b0, DSH_32, DEN_KF, 1'b1, 2'd0);
      5'd27: u = mk(OP_DIV, SRC_T2, SRC_T2, SRC_TZ, 1'b0, DSH_30, DEN_KM, 1'b1, 2'd0);
      default: u = mk(OP_SQRT, SRC_TA, SRC_TA, SRC_TA, 1'b0, DSH_15, DEN_KF, 1'b0,
                      step[1:0]);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

### sv/quadrotor_rate_and_motor_mixer.sv
// Top level of the quadrotor body-rate controller and X-frame motor mixer.
//
//  channel  | direction | contents
//  ---------+-----------+--------------------------------------------------
//  s_axis   | in        | tuser: mode; tdata: command words 0..3, rates x,y,z
//  m_axis   | out       | tdata: rotor speeds 0..3; tuser: unknown_mode
//  cfg      | in        | write enable, register index, 63-bit data
//
// Mode 0 runs 16 multiplies on the shared shift-add multiplier, 6 divides on the
// restoring divider, 4 roots, and 6 saturating adds. Mode 1 runs the divides and
// roots only; modes 2 and 3 skip the micro-program.
// One beat is worked at a time; a new beat is taken while the last result waits.
// Reset (rst, synchronous) restores the default coefficients and zero held speeds.
`default_nettype none

module quadrotor_rate_and_motor_mixer import qrm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [1:0]        s_axis_tuser,   // mode
  input  logic [223:0]      s_axis_tdata,   // command_word_0..3, rate_x, rate_y, rate_z
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [127:0]      m_axis_tdata,   // rotor_speed_0..3
  output logic [0:0]        m_axis_tuser,   // unknown_mode
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [COEF_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  logic [WORD_W-1:0] rs0, rs1, rs2, rs3;
  logic              unk;

  qrm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_mode   (mode_t'(s_axis_tuser)),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .status    (status)
  );

  qrm_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mode           (mode_t'(s_axis_tuser)),
    .command_word_0 (s_axis_tdata[31:0]),
    .command_word_1 (s_axis_tdata[63:32]),
    .command_word_2 (s_axis_tdata[95:64]),
    .command_word_3 (s_axis_tdata[127:96]),
    .rate_x         (s_axis_tdata[159:128]),
    .rate_y         (s_axis_tdata[191:160]),
    .rate_z         (s_axis_tdata[223:192]),
    .rotor_speed_0  (rs0),
    .rotor_speed_1  (rs1),
    .rotor_speed_2  (rs2),
    .rotor_speed_3  (rs3),
    .unknown_mode   (unk)
  );

  assign m_axis_tdata = {rs3, rs2, rs1, rs0};
  assign m_axis_tuser = unk;

endmodule

`default_nettype wire

### sv/qrm_ctrl.sv
// Sequencer: accepts a beat, walks the micro-program, commits the result beat.
`default_nettype none

module qrm_ctrl import qrm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  mode_t   in_mode,
  output logic    out_valid,
  input  logic    out_ready,
  output cmd_t    cmd,
  input  status_t status
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_BUSY  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              out_valid_next;
  logic              accept;
  logic              commit;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state == ST_DONE) && (!out_valid || out_ready);

  // Next state and step
  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_mode) inside
            MODE_RATE: begin
              step_next  = '0;
              state_next = ST_ISSUE;
            end
            MODE_TORQUE: begin
              step_next  = STEP_DIV0;
              state_next = ST_ISSUE;
            end
            MODE_SPEED, MODE_UNKNOWN: state_next = ST_DONE;
          endcase
        end
      end
      ST_ISSUE: state_next = ST_BUSY;
      ST_BUSY: begin
        if (status.done) begin
          if (step == STEP_LAST) begin
            state_next = ST_DONE;
          end else begin
            step_next  = step + 1'b1;
            state_next = ST_ISSUE;
          end
        end
      end
      ST_DONE: begin
        if (commit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output beat valid: set on commit, cleared when taken
  always_comb begin
    out_valid_next = out_valid;
    if (commit) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  // Commands to the datapath
  assign cmd.load   = accept;
  assign cmd.start  = (state == ST_ISSUE);
  assign cmd.commit = commit;
  assign cmd.uop    = uop_at(step);

endmodule

`default_nettype wire

### sv/qrm_dpath.sv
// Datapath: configuration, operand registers, shared serial multiply, divide and root units.
`default_nettype none

module qrm_dpath import qrm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [COEF_W-1:0] cfg_data,
  input  mode_t             mode,
  input  logic [WORD_W-1:0] command_word_0,
  input  logic [WORD_W-1:0] command_word_1,
  input  logic [WORD_W-1:0] command_word_2,
  input  logic [WORD_W-1:0] command_word_3,
  input  logic [WORD_W-1:0] rate_x,
  input  logic [WORD_W-1:0] rate_y,
  input  logic [WORD_W-1:0] rate_z,
  output logic [WORD_W-1:0] rotor_speed_0,
  output logic [WORD_W-1:0] rotor_speed_1,
  output logic [WORD_W-1:0] rotor_speed_2,
  output logic [WORD_W-1:0] rotor_speed_3,
  output logic              unknown_mode
);

  typedef struct packed {
    logic [63:0] f, t0, t1, t2, jw0, jw1, jw2, p, q, g, ax, ay, ta, tx, ty, tz;
  } regs_t;

  typedef struct packed {
    logic [63:0] u0, w0, w1, w2, e0, e1, e2, jd0, jd1, jd2, mass;
  } opin_t;

  function automatic logic [63:0] sext(logic [WORD_W-1:0] v);
    return {{(64-WORD_W){v[WORD_W-1]}}, v};
  endfunction

  function automatic logic [63:0] mag(logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] pick(src_t s, regs_t r, opin_t x);
    logic [63:0] v;
    case (s)
      SRC_F:    v = r.f;
      SRC_T0:   v = r.t0;
      SRC_T1:   v = r.t1;
      SRC_T2:   v = r.t2;
      SRC_JW0:  v = r.jw0;
      SRC_JW1:  v = r.jw1;
      SRC_JW2:  v = r.jw2;
      SRC_P:    v = r.p;
      SRC_Q:    v = r.q;
      SRC_G:    v = r.g;
      SRC_AX:   v = r.ax;
      SRC_AY:   v = r.ay;
      SRC_TA:   v = r.ta;
      SRC_TX:   v = r.tx;
      SRC_TY:   v = r.ty;
      SRC_TZ:   v = r.tz;
      SRC_U0:   v = x.u0;
      SRC_W0:   v = x.w0;
      SRC_W1:   v = x.w1;
      SRC_W2:   v = x.w2;
      SRC_E0:   v = x.e0;
      SRC_E1:   v = x.e1;
      SRC_E2:   v = x.e2;
      SRC_JD0:  v = x.jd0;
      SRC_JD1:  v = x.jd1;
      SRC_JD2:  v = x.jd2;
      SRC_GXY:  v = GAIN_XY;
      SRC_GZ:   v = GAIN_Z;
      SRC_MASS: v = x.mass;
      default:  v = '0;
    endcase
    return v;
  endfunction

  function automatic regs_t put(regs_t r, src_t d, logic [63:0] v);
    regs_t n;
    n = r;
    case (d)
      SRC_F:   n.f   = v;
      SRC_T0:  n.t0  = v;
      SRC_T1:  n.t1  = v;
      SRC_T2:  n.t2  = v;
      SRC_JW0: n.jw0 = v;
      SRC_JW1: n.jw1 = v;
      SRC_JW2: n.jw2 = v;
      SRC_P:   n.p   = v;
      SRC_Q:   n.q   = v;
      SRC_G:   n.g   = v;
      SRC_AX:  n.ax  = v;
      SRC_AY:  n.ay  = v;
      SRC_TA:  n.ta  = v;
      SRC_TX:  n.tx  = v;
      SRC_TY:  n.ty  = v;
      SRC_TZ:  n.tz  = v;
      default: n     = r;
    endcase
    return n;
  endfunction

  // Configuration registers
  logic [WORD_W-1:0] mass, arm, jxx, jyy, jzz;
  logic [COEF_W-1:0] kf, km;

  always_ff @(posedge clk) begin
    if (rst) begin
      mass <= MASS_RST;
      kf   <= KF_RST;
      km   <= KM_RST;
      arm  <= ARM_RST;
      jxx  <= JXX_RST;
      jyy  <= JYY_RST;
      jzz  <= JZZ_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MASS: mass <= cfg_data[WORD_W-1:0];
        CFG_KF:   kf   <= cfg_data;
        CFG_KM:   km   <= cfg_data;
        CFG_ARM:  arm  <= cfg_data[WORD_W-1:0];
        CFG_JXX:  jxx  <= cfg_data[WORD_W-1:0];
        CFG_JYY:  jyy  <= cfg_data[WORD_W-1:0];
        CFG_JZZ:  jzz  <= cfg_data[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured input beat
  mode_t                         mode_q;
  logic [ROTOR_COUNT-1:0][WORD_W-1:0] u_q;
  logic [2:0][WORD_W-1:0]        w_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= mode;
      u_q    <= {command_word_3, command_word_2, command_word_1, command_word_0};
      w_q    <= {rate_z, rate_y, rate_x};
    end
  end

  // Operand selection
  regs_t       rf;
  opin_t       opin;
  logic [63:0] a_val, b_val;

  always_comb begin
    opin.u0   = sext(u_q[0]);
    opin.w0   = sext(w_q[0]);
    opin.w1   = sext(w_q[1]);
    opin.w2   = sext(w_q[2]);
    opin.e0   = sext(u_q[1]) - sext(w_q[0]);
    opin.e1   = sext(u_q[2]) - sext(w_q[1]);
    opin.e2   = sext(u_q[3]) - sext(w_q[2]);
    opin.jd0  = {32'd0, jxx};
    opin.jd1  = {32'd0, jyy};
    opin.jd2  = {32'd0, jzz};
    opin.mass = {32'd0, mass};
  end

  assign a_val = pick(cmd.uop.a, rf, opin);
  assign b_val = pick(cmd.uop.b, rf, opin);

  // Saturating add and subtract
  logic signed [64:0] sum_w;
  logic [63:0]        sum_sat;

  always_comb begin
    if (cmd.uop.op == OP_SUB) sum_w = $signed({a_val[63], a_val}) - $signed({b_val[63], b_val});
    else sum_w = $signed({a_val[63], a_val}) + $signed({b_val[63], b_val});
    if (sum_w > $signed({1'b0, SAT_MAX})) sum_sat = SAT_MAX;
    else if (sum_w < -$signed({1'b0, SAT_MAX})) sum_sat = 64'd0 - SAT_MAX;
    else sum_sat = sum_w[63:0];
  end

  // Squared speed of the selected rotor for the X mixer
  logic [63:0] sq_sel;

  always_comb begin
    case (cmd.uop.rotor)
      2'd0:    sq_sel = rf.ta - rf.ty + rf.tz;
      2'd1:    sq_sel = rf.ta + rf.ty + rf.tz;
      2'd2:    sq_sel = rf.ta + rf.tx - rf.tz;
      default: sq_sel = rf.ta - rf.tx - rf.tz;
    endcase
  end

  // Divider start values
  logic [63:0]        div_n;
  logic [63:0]        b_mag;
  logic [DIV_N_W-1:0] div_shifted;
  logic [63:0]        den_sel;

  assign div_n = mag(a_val);
  assign b_mag = mag(b_val);

  always_comb begin
    case (cmd.uop.dsh)
      DSH_15:  div_shifted = {32'd0, div_n} << 15;
      DSH_30:  div_shifted = {32'd0, div_n} << 30;
      default: div_shifted = {32'd0, div_n} << 32;
    endcase
    case (cmd.uop.den)
      DEN_KF:  den_sel = {1'b0, kf};
      DEN_KM:  den_sel = {1'b0, km};
      default: den_sel = {32'd0, arm};
    endcase
  end

  // Unit state
  logic                busy, fin;
  logic [CNT_W-1:0]    cnt;
  logic                neg, nzero;
  logic [MUL_P_W-1:0]  acc;
  logic [63:0]         ma;
  logic [MUL_B_W-1:0]  mb;
  logic [DIV_N_W-1:0]  dvd;
  logic [63:0]         rem, den;
  logic [63:0]         sx, sres, sbit;
  logic [ROTOR_COUNT-1:0][WORD_W-1:0] held;

  // One step of each unit
  logic [64:0]        mul_sum;
  logic [63:0]        div_r2;
  logic               div_ge;
  logic [63:0]        sqrt_t;
  logic [CNT_W-1:0]   cnt_last;

  assign mul_sum = {1'b0, acc[MUL_P_W-1:MUL_B_W]} + (mb[0] ? {1'b0, ma} : 65'd0);
  assign div_r2  = {rem[62:0], dvd[DIV_N_W-1]};
  assign div_ge  = (div_r2 >= den);
  assign sqrt_t  = sres + sbit;

  always_comb begin
    case (cmd.uop.op)
      OP_MUL:  cnt_last = MUL_LAST;
      OP_DIV:  cnt_last = DIV_LAST;
      default: cnt_last = SQRT_LAST;
    endcase
  end

  // Final results
  logic [MUL_P_W-1:0] mul_shv;
  logic [63:0]        mul_mag, mul_res;
  logic [63:0]        div_lim, div_mag, div_res;

  always_comb begin
    mul_shv = cmd.uop.sh16 ? (acc >> 16) : acc;
    mul_mag = (|mul_shv[MUL_P_W-1:63]) ? SAT_MAX : {1'b0, mul_shv[62:0]};
    mul_res = neg ? (64'd0 - mul_mag) : mul_mag;
    div_lim = cmd.uop.term ? TERM_MAX : SAT_MAX;
    div_mag = ((|dvd[DIV_N_W-1:64]) || (dvd[63:0] > div_lim)) ? div_lim : dvd[63:0];
    div_res = nzero ? 64'd0 : (neg ? (64'd0 - div_mag) : div_mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      held <= '0;
    end else begin
      fin <= 1'b0;
      // Preload force and torques scaled from the command words
      if (cmd.load) begin
        rf.f  <= {{16{command_word_0[WORD_W-1]}}, command_word_0, 16'd0};
        rf.t0 <= {{16{command_word_1[WORD_W-1]}}, command_word_1, 16'd0};
        rf.t1 <= {{16{command_word_2[WORD_W-1]}}, command_word_2, 16'd0};
        rf.t2 <= {{16{command_word_3[WORD_W-1]}}, command_word_3, 16'd0};
      end
      if (cmd.start) begin
        cnt <= '0;
        case (cmd.uop.op)
          OP_MUL: begin
            ma   <= mag(a_val);
            mb   <= b_mag[MUL_B_W-1:0];
            acc  <= '0;
            neg  <= a_val[63] ^ b_val[63];
            busy <= 1'b1;
          end
          OP_DIV: begin
            dvd   <= div_shifted;
            rem   <= '0;
            den   <= den_sel;
            neg   <= a_val[63];
            nzero <= (div_n == 64'd0);
            busy  <= 1'b1;
          end
          OP_SQRT: begin
            sx   <= sq_sel[63] ? 64'd0 : sq_sel;
            sres <= '0;
            sbit <= 64'd1 << 62;
            busy <= 1'b1;
          end
          default: begin
            rf  <= put(rf, cmd.uop.dst, sum_sat);
            fin <= 1'b1;
          end
        endcase
      end
      // Iterate the active unit
      if (busy) begin
        cnt <= cnt + 1'b1;
        case (cmd.uop.op)
          OP_MUL: begin
            acc <= {mul_sum, acc[MUL_B_W-1:1]};
            mb  <= mb >> 1;
          end
          OP_DIV: begin
            rem <= div_ge ? (div_r2 - den) : div_r2;
            dvd <= {dvd[DIV_N_W-2:0], div_ge};
          end
          default: begin
            if (sx >= sqrt_t) begin
              sx   <= sx - sqrt_t;
              sres <= (sres >> 1) + sbit;
            end else begin
              sres <= sres >> 1;
            end
            sbit <= sbit >> 2;
          end
        endcase
        if (cnt == cnt_last) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
      // Write back
      if (fin) begin
        case (cmd.uop.op)
          OP_MUL:  rf <= put(rf, cmd.uop.dst, mul_res);
          OP_DIV:  rf <= put(rf, cmd.uop.dst, div_res);
          OP_SQRT: held[cmd.uop.rotor] <= sres[WORD_W-1:0];
          default: ;
        endcase
      end
      // Direct speeds replace the held ones on commit
      if (cmd.commit && mode_q == MODE_SPEED) begin
        for (int i = 0; i < ROTOR_COUNT; i++) begin
          held[i] <= u_q[i][WORD_W-1] ? '0 : {8'd0, u_q[i][WORD_W-1:8]};
        end
      end
    end
  end

  // Output beat register
  logic [ROTOR_COUNT-1:0][WORD_W-1:0] out_q;
  logic                               unk_q;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < ROTOR_COUNT; i++) begin
        if (mode_q == MODE_SPEED) begin
          out_q[i] <= u_q[i][WORD_W-1] ? '0 : {8'd0, u_q[i][WORD_W-1:8]};
        end else begin
          out_q[i] <= held[i];
        end
      end
      unk_q <= (mode_q == MODE_UNKNOWN);
    end
  end

  assign rotor_speed_0 = out_q[0];
  assign rotor_speed_1 = out_q[1];
  assign rotor_speed_2 = out_q[2];
  assign rotor_speed_3 = out_q[3];
  assign unknown_mode  = unk_q;
  assign status.done   = fin;

endmodule

`default_nettype wire

### sv/qrm_checker.sv
// Port-level checks on the rate controller and motor mixer, bound to the top level.
`default_nettype none
`include "quadrotor_rate_and_motor_mixer_defines.svh"

module qrm_checker import qrm_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [1:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic [0:0]   m_axis_tuser
);

  // Result beat stays offered until taken
  `QRM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "out beat dropped")

  // Stalled result beat keeps its payload
  `QRM_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "out payload moved")

  // One beat in work at a time
  `QRM_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second beat taken while busy")

  // Unknown mode answers straight from the done state with the flag set
  `QRM_ASSERT_TWO(a_unknown_fast, s_axis_tvalid && s_axis_tready && s_axis_tuser == MODE_UNKNOWN && !m_axis_tvalid, m_axis_tvalid && m_axis_tuser[0], "unknown mode not flagged")

  // Direct speeds answer straight from the done state without the flag
  `QRM_ASSERT_TWO(a_speed_fast, s_axis_tvalid && s_axis_tready && s_axis_tuser == MODE_SPEED && !m_axis_tvalid, m_axis_tvalid && !m_axis_tuser[0], "direct speed beat late")

endmodule

bind quadrotor_rate_and_motor_mixer qrm_checker u_checker (.*);

`default_nettype wire

### tb/sv/qrm_scoreboard.sv
// Checker for the rate controller and motor mixer: predicts rotor speeds and compares beats.
`default_nettype none

module qrm_scoreboard import qrm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  input  wire logic              s_axis_tready,
  input  wire logic [1:0]        s_axis_tuser,   // mode
  input  wire logic [223:0]      s_axis_tdata,   // command_word_0..3, rate_x, rate_y, rate_z
  input  wire logic              m_axis_tvalid,
  input  wire logic              m_axis_tready,
  input  wire logic [127:0]      m_axis_tdata,   // rotor_speed_0..3
  input  wire logic [0:0]        m_axis_tuser,   // unknown_mode
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [COEF_W-1:0] cfg_data,
  output int                     fail_count,
  output int                     pending
);

  typedef struct {
    logic [31:0] speed[ROTOR_COUNT];
    logic        unknown;
  } speeds_t;

  speeds_t     speed_queue[$];
  logic [63:0] mass_q, kf_q, km_q, arm_q;
  logic [63:0] inertia_q[3];
  logic [31:0] held_q[ROTOR_COUNT];

  function automatic logic [63:0] magnitude(longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic longint signed_of(logic neg, logic [63:0] m);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // (a*b) >> sh, truncated toward zero, saturated to +-lim
  function automatic longint scaled_product(longint a, longint b, int sh, logic [63:0] lim);
    logic [127:0] p;
    p = ({64'd0, magnitude(a)} * {64'd0, magnitude(b)}) >> sh;
    if (p > {64'd0, lim}) p = {64'd0, lim};
    return signed_of((a < 0) != (b < 0), p[63:0]);
  endfunction

  // (num << sh) / den, truncated toward zero, saturated; zero divisor gives the limit
  function automatic longint scaled_quotient(longint num, int sh, logic [63:0] den,
                                             logic [63:0] lim);
    logic [127:0] q;
    if (num == 0) return 0;
    if (den == 0) return signed_of(num < 0, lim);
    q = ({64'd0, magnitude(num)} << sh) / {64'd0, den};
    if (q > {64'd0, lim}) q = {64'd0, lim};
    return signed_of(num < 0, q[63:0]);
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return longint'(SAT_MAX);
    if (s < -65'sh0_7FFF_FFFF_FFFF_FFFF) return -longint'(SAT_MAX);
    return longint'(s[63:0]);
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Rotor speeds for one command beat; updates the held speeds
  function automatic speeds_t mix_command(mode_t mode, logic [223:0] data);
    speeds_t res;
    longint  u[4], w[3], jw[3], g[3], torque[3], sq[ROTOR_COUNT];
    longint  thrust, jk, err, t1, ax, ay, tx, ty, tz;
    logic [63:0] gain, s;
    for (int i = 0; i < 4; i++) u[i] = longint'($signed(data[32*i +: 32]));
    for (int i = 0; i < 3; i++) w[i] = longint'($signed(data[32*(4+i) +: 32]));
    thrust = 0;
    for (int i = 0; i < 3; i++) torque[i] = 0;
    if (mode == MODE_RATE) begin
      thrust = scaled_product(u[0], longint'(mass_q), 0, SAT_MAX);
      for (int i = 0; i < 3; i++) begin
        gain = (i == 2) ? GAIN_Z : GAIN_XY;
        err = u[1+i] - w[i];
        jk = longint'(inertia_q[i] * gain);
        jw[i] = scaled_product(longint'(inertia_q[i]), w[i], 0, SAT_MAX);
        torque[i] = scaled_product(jk, err, 16, SAT_MAX);
      end
      // gyroscopic term omega x (J omega)
      g[0] = sat_sum(scaled_product(w[1], jw[2], 16, SAT_MAX),
                     -scaled_product(w[2], jw[1], 16, SAT_MAX));
      g[1] = sat_sum(scaled_product(w[2], jw[0], 16, SAT_MAX),
                     -scaled_product(w[0], jw[2], 16, SAT_MAX));
      g[2] = sat_sum(scaled_product(w[0], jw[1], 16, SAT_MAX),
                     -scaled_product(w[1], jw[0], 16, SAT_MAX));
      for (int i = 0; i < 3; i++) torque[i] = sat_sum(torque[i], g[i]);
    end else if (mode == MODE_TORQUE) begin
      thrust = u[0] * 65536;
      for (int i = 0; i < 3; i++) torque[i] = u[1+i] * 65536;
    end
    if (mode == MODE_RATE || mode == MODE_TORQUE) begin
      t1 = scaled_quotient(thrust, 30, kf_q, TERM_MAX);
      ax = scaled_quotient(torque[0], 15, arm_q, SAT_MAX);
      ay = scaled_quotient(torque[1], 15, arm_q, SAT_MAX);
      tx = scaled_quotient(ax, 32, kf_q, TERM_MAX);
      ty = scaled_quotient(ay, 32, kf_q, TERM_MAX);
      tz = scaled_quotient(torque[2], 30, km_q, TERM_MAX);
      sq[0] = t1 - ty + tz;
      sq[1] = t1 + ty + tz;
      sq[2] = t1 + tx - tz;
      sq[3] = t1 - tx - tz;
      for (int i = 0; i < ROTOR_COUNT; i++) begin
        s = sq[i] > 0 ? root_floor(64'(sq[i])) : 64'd0;
        if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
        held_q[i] = s[31:0];
      end
    end else if (mode == MODE_SPEED) begin
      for (int i = 0; i < ROTOR_COUNT; i++)
        held_q[i] = u[i] < 0 ? 32'd0 : 32'(u[i] >>> 8);
    end
    for (int i = 0; i < ROTOR_COUNT; i++) res.speed[i] = held_q[i];
    res.unknown = (mode == MODE_UNKNOWN);
    return res;
  endfunction

  task automatic report(string what, int idx, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s[%0d] got %0h expected %0h", $realtime, what, idx, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    speeds_t want;
    if (rst) begin
      mass_q       <= 64'(MASS_RST);
      kf_q         <= 64'(KF_RST);
      km_q         <= 64'(KM_RST);
      arm_q        <= 64'(ARM_RST);
      inertia_q[0] <= 64'(JXX_RST);
      inertia_q[1] <= 64'(JYY_RST);
      inertia_q[2] <= 64'(JZZ_RST);
      for (int i = 0; i < ROTOR_COUNT; i++) held_q[i] <= '0;
      speed_queue.delete();
      pending <= 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_MASS: mass_q       <= 64'(cfg_data[31:0]);
          CFG_KF:   kf_q         <= 64'(cfg_data);
          CFG_KM:   km_q         <= 64'(cfg_data);
          CFG_ARM:  arm_q        <= 64'(cfg_data[31:0]);
          CFG_JXX:  inertia_q[0] <= 64'(cfg_data[31:0]);
          CFG_JYY:  inertia_q[1] <= 64'(cfg_data[31:0]);
          CFG_JZZ:  inertia_q[2] <= 64'(cfg_data[31:0]);
          default: ;
        endcase
      end
      // command beat
      if (s_axis_tvalid && s_axis_tready)
        speed_queue.push_back(mix_command(mode_t'(s_axis_tuser), s_axis_tdata));
      // result beat
      if (m_axis_tvalid && m_axis_tready) begin
        if (speed_queue.size() == 0) begin
          $display("unexpected result beat at %0t", $realtime);
          fail_count++;
        end else begin
          want = speed_queue.pop_front();
          for (int i = 0; i < ROTOR_COUNT; i++)
            if (m_axis_tdata[32*i +: 32] !== want.speed[i])
              report("rotor_speed", i, m_axis_tdata[32*i +: 32], want.speed[i]);
          if (m_axis_tuser[0] !== want.unknown)
            report("unknown_mode", 0, 32'(m_axis_tuser[0]), 32'(want.unknown));
        end
      end
      pending <= speed_queue.size();
    end
  end

  initial fail_count = 0;

endmodule

`default_nettype wire

### tb/sv/tb_quadrotor_rate_and_motor_mixer.sv
// Stimulus and verdict for the rate controller and motor mixer testbench.
`default_nettype none

module tb_quadrotor_rate_and_motor_mixer;
  import qrm_pkg::*;

  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int         IDLE_LIMIT = 30000;
  localparam int         HOLD_LEN   = 4000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [1:0]        s_axis_tuser = '0;   // mode
  logic [223:0]      s_axis_tdata = '0;   // command_word_0..3, rate_x, rate_y, rate_z
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [127:0]      m_axis_tdata;        // rotor_speed_0..3
  logic [0:0]        m_axis_tuser;        // unknown_mode
  logic              cfg_we = 1'b0;
  logic [2:0]        cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;
  int                fail_count, pending, idle_cycles, result_beats;
  logic              no_gaps = 1'b0;

  quadrotor_rate_and_motor_mixer DUT (.*);

  qrm_scoreboard checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic int draw_gap();
    if (no_gaps) return 0;
    return $urandom_range(0, 17);
  endfunction

  // result side: random stalls, one long hold-off early on
  initial begin
    int gap;
    result_beats = 0;
    @(negedge rst);
    forever begin
      gap = (result_beats == 6) ? HOLD_LEN : draw_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(negedge clk); while (!m_axis_tvalid);
      @(posedge clk);
      result_beats++;
    end
  end

  task automatic send_command(mode_t mode, int w0, int w1, int w2, int w3,
                              int rx, int ry, int rz);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {rz, ry, rx, w3, w2, w1, w0};
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
  endtask

  // lower valid and wait until every result is back, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [COEF_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic write_all(logic [31:0] mass, logic [62:0] kf, logic [62:0] km,
                           logic [31:0] arm, logic [31:0] jxx, logic [31:0] jyy,
                           logic [31:0] jzz);
    write_reg(CFG_MASS, 63'(mass));
    write_reg(CFG_KF, kf);
    write_reg(CFG_KM, km);
    write_reg(CFG_ARM, 63'(arm));
    write_reg(CFG_JXX, 63'(jxx));
    write_reg(CFG_JYY, 63'(jyy));
    write_reg(CFG_JZZ, 63'(jzz));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // small signed Q16.16 value, mostly near flight range
  function automatic int near(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int any_word();
    return ($urandom_range(0, 3) == 0) ? int'($urandom) : near(1 << 20);
  endfunction

  task automatic random_commands(int count);
    int   pick;
    mode_t mode;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      mode = pick < 35 ? MODE_RATE : pick < 65 ? MODE_TORQUE :
             pick < 85 ? MODE_SPEED : MODE_UNKNOWN;
      if (mode == MODE_RATE && $urandom_range(0, 3) != 0)
        // hover-like: about 1 g plus small rate commands and rates
        send_command(mode, 642252 + near(200000), near(300000), near(300000),
                     near(300000), near(300000), near(300000), near(300000));
      else if (mode == MODE_TORQUE && $urandom_range(0, 3) != 0)
        send_command(mode, near(1 << 20), near(2000), near(2000), near(400),
                     any_word(), any_word(), any_word());
      else
        send_command(mode, any_word(), any_word(), any_word(), any_word(),
                     any_word(), any_word(), any_word());
    end
  endtask

  localparam int MAX_P = 32'h7FFF_FFFF;
  localparam int MIN_N = 32'h8000_0000;

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: pass-through extremes, held speeds, unknown mode
    send_command(MODE_SPEED, MAX_P, MIN_N, 0, 32'h100, 0, 0, 0);
    send_command(MODE_UNKNOWN, MIN_N, MAX_P, -1, 1, MIN_N, MAX_P, -1);
    send_command(MODE_SPEED, -1, 255, 32'h1FF, MAX_P, 0, 0, 0);
    send_command(MODE_UNKNOWN, 0, 0, 0, 0, 0, 0, 0);
    // torque mode: zero, positive, negative squared speeds, extremes
    send_command(MODE_TORQUE, 0, 0, 0, 0, 0, 0, 0);
    send_command(MODE_TORQUE, 1 << 20, 0, 0, 0, 0, 0, 0);
    send_command(MODE_TORQUE, -(1 << 20), 0, 0, 0, 0, 0, 0);
    send_command(MODE_TORQUE, 1 << 18, 1 << 16, -(1 << 16), 1 << 14, 0, 0, 0);
    send_command(MODE_TORQUE, MAX_P, MAX_P, MIN_N, MAX_P, 0, 0, 0);
    send_command(MODE_TORQUE, MIN_N, MIN_N, MAX_P, MIN_N, 0, 0, 0);
    // rate mode: hover, rate errors, extreme rates for saturation
    send_command(MODE_RATE, 642252, 0, 0, 0, 0, 0, 0);
    send_command(MODE_RATE, 642252, 65536, -65536, 32768, 0, 0, 0);
    send_command(MODE_RATE, 642252, 0, 0, 0, 131072, -196608, 65536);
    send_command(MODE_RATE, MAX_P, MAX_P, MIN_N, MAX_P, MIN_N, MAX_P, MIN_N);
    send_command(MODE_RATE, MIN_N, MIN_N, MAX_P, MIN_N, MAX_P, MIN_N, MAX_P);
    send_command(MODE_UNKNOWN, 1, 2, 3, 4, 5, 6, 7);
    random_commands(150);
    drain();

    // largest mass and inertia, smallest coefficients and arm: saturation
    write_all(32'hFFFF_FFFF, 63'd1, 63'd1, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    write_reg(CFG_UNUSED, '1);
    cfg_we <= 1'b0;
    send_command(MODE_TORQUE, 1, -1, 1, -1, 0, 0, 0);
    send_command(MODE_RATE, 1, 0, 0, 0, 1, 1, 1);
    random_commands(120);
    drain();

    // zero divisors and zero mass; no idling in this phase
    no_gaps <= 1'b1;
    write_all(32'd0, 63'd0, 63'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_command(MODE_TORQUE, 0, 0, 0, 0, 0, 0, 0);
    send_command(MODE_TORQUE, 5, -5, 5, -5, 0, 0, 0);
    random_commands(100);
    drain();

    // largest coefficients
    no_gaps <= 1'b0;
    write_all(32'd1, {63{1'b1}}, {63{1'b1}}, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1);
    random_commands(100);
    drain();

    // near-nominal vehicle with random spread
    write_all(32'd65536 + $urandom_range(0, 65536), 63'd2527638 + $urandom_range(0, 1 << 20),
              63'd253000 + $urandom_range(0, 1 << 18), 32'd17039 + $urandom_range(0, 8000),
              32'd164 + $urandom_range(0, 200), 32'd164 + $urandom_range(0, 200),
              32'd295 + $urandom_range(0, 300));
    random_commands(260);
    drain();

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
